// ===== hdl/histogram_with_overflow_bin_macros.svh =====
// Assertion macros for the histogram block and its checker.
// Included by the checker only; no other dependencies.
`ifndef HISTOGRAM_WITH_OVERFLOW_BIN_MACROS_SVH
`define HISTOGRAM_WITH_OVERFLOW_BIN_MACROS_SVH

// same-cycle implication
`define HWOB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HWOB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hwob_pkg.sv =====
// Shared types and constants of the histogram block.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps

package hwob_pkg;

	localparam int DEF_NUM_BINS    = 1024;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam int CFG_W    = 11;
	localparam int IN_IDX_W = 16;
	localparam int WIDE_W   = IN_IDX_W + 1;
	localparam int OUT_W    = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// request modes
	localparam logic [1:0] MODE_RECORD  = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_SUMMARY = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_CLAMPED = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_UPDATE,
		S_SUM,
		S_SUM_END,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic lookup;
		logic sum_start;
		logic sum_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sum_last;
		logic is_summary;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/hwob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hwob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/hwob_ctrl.sv =====
// Sequencer of the histogram block: clear pass, request handling, bin walk.
// Depends on hwob_pkg.
`timescale 1ns / 1ps

module hwob_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  hwob_pkg::sts_t sts,
	output hwob_pkg::cmd_t cmd
);

	hwob_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hwob_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			hwob_pkg::S_CLEAR: begin
				if (sts.clr_last) state_nx = hwob_pkg::S_IDLE;
			end
			hwob_pkg::S_IDLE: begin
				if (req_valid) state_nx = hwob_pkg::S_LOOKUP;
			end
			hwob_pkg::S_LOOKUP: begin
				state_nx = sts.is_summary ? hwob_pkg::S_SUM : hwob_pkg::S_UPDATE;
			end
			hwob_pkg::S_UPDATE: begin
				if (sts.out_free) state_nx = hwob_pkg::S_IDLE;
			end
			hwob_pkg::S_SUM: begin
				if (sts.sum_last) state_nx = hwob_pkg::S_SUM_END;
			end
			hwob_pkg::S_SUM_END: begin
				state_nx = hwob_pkg::S_FINISH;
			end
			hwob_pkg::S_FINISH: begin
				if (sts.out_free) state_nx = hwob_pkg::S_IDLE;
			end
			default: begin
				state_nx = hwob_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			hwob_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			hwob_pkg::S_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_item = req_valid;
			end
			hwob_pkg::S_LOOKUP: begin
				cmd.sum_start = sts.is_summary;
				cmd.lookup    = !sts.is_summary;
			end
			hwob_pkg::S_UPDATE, hwob_pkg::S_FINISH: begin
				cmd.commit = sts.out_free;
			end
			hwob_pkg::S_SUM: begin
				cmd.sum_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/hwob_dp.sv =====
// Datapath of the histogram block: bin memory, counters, summary adder,
// output register. Depends on hwob_pkg and hwob_ram.
`timescale 1ns / 1ps

module hwob_dp #(
	parameter int NUM_BINS    = hwob_pkg::DEF_NUM_BINS,
	parameter int COUNT_WIDTH = hwob_pkg::DEF_COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hwob_pkg::cmd_t                cmd,
	output hwob_pkg::sts_t                sts,
	input  logic [hwob_pkg::CFG_W-1:0]    cfg_bins,
	input  logic [1:0]                    in_mode,
	input  logic [hwob_pkg::IN_IDX_W-1:0] in_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [hwob_pkg::OUT_W-1:0]    out_count,
	output logic [hwob_pkg::IN_IDX_W-1:0] out_largest,
	output logic [hwob_pkg::OUT_W-1:0]    out_overflow,
	output logic                          out_agree
);

	localparam int IDX_W = $clog2(NUM_BINS);
	localparam int WW    = hwob_pkg::WIDE_W;
	localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

	logic [1:0]                    mode_q;
	logic [hwob_pkg::IN_IDX_W-1:0] index_q;
	logic [IDX_W-1:0]              ptr_q;
	logic                          acc_en_s1;
	logic [COUNT_WIDTH-1:0]        acc_q, total_q, ovf_q;
	logic [hwob_pkg::IN_IDX_W-1:0] largest_q;
	logic                          valid_q;

	logic [WW-1:0]          cfg_w, eff_w, last_w;
	logic [IDX_W-1:0]       last_idx, item_addr;
	logic                   over, is_record;
	logic                   ram_we, ram_re;
	logic [IDX_W-1:0]       ram_waddr, ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [COUNT_WIDTH-1:0] bin_inc, tot_inc, ovf_inc, total_nx, ovf_nx, cnt;
	logic [COUNT_WIDTH:0]   acc_sum;
	logic [hwob_pkg::IN_IDX_W-1:0] largest_nx;
	logic [1:0]             stat;
	logic                   agree;

	// effective bins in use: zero reads as one, above NUM_BINS as NUM_BINS
	always_comb begin
		cfg_w = WW'(cfg_bins);
		if (cfg_w == '0) begin
			eff_w = WW'(1);
		end else if (cfg_w > WW'(NUM_BINS)) begin
			eff_w = WW'(NUM_BINS);
		end else begin
			eff_w = cfg_w;
		end
		last_w   = eff_w - WW'(1);
		last_idx = last_w[IDX_W-1:0];
	end

	assign over      = WW'(index_q) > last_w;
	assign item_addr = over ? last_idx : index_q[IDX_W-1:0];
	assign is_record = mode_q == hwob_pkg::MODE_RECORD;

	// saturating increments
	assign bin_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
	assign tot_inc = (total_q == '1) ? total_q : total_q + COUNT_WIDTH'(1);
	assign ovf_inc = (ovf_q == '1) ? ovf_q : ovf_q + COUNT_WIDTH'(1);
	assign acc_sum = {1'b0, acc_q} + {1'b0, ram_rdata};

	assign ram_we    = cmd.clr_step | (cmd.commit & is_record);
	assign ram_waddr = cmd.clr_step ? ptr_q : item_addr;
	assign ram_wdata = cmd.clr_step ? '0 : bin_inc;
	assign ram_re    = cmd.lookup | cmd.sum_step;
	assign ram_raddr = cmd.sum_step ? ptr_q : item_addr;

	hwob_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign total_nx   = is_record ? tot_inc : total_q;
	assign ovf_nx     = (is_record && over) ? ovf_inc : ovf_q;
	assign largest_nx = (is_record && index_q > largest_q) ? index_q : largest_q;

	always_comb begin
		stat  = hwob_pkg::STAT_OK;
		cnt   = '0;
		agree = 1'b0;
		case (mode_q)
			hwob_pkg::MODE_RECORD: begin
				stat = over ? hwob_pkg::STAT_CLAMPED : hwob_pkg::STAT_OK;
				cnt  = tot_inc;
			end
			hwob_pkg::MODE_READ: begin
				if (over) begin
					stat = hwob_pkg::STAT_INVALID;
				end else begin
					cnt = ram_rdata;
				end
			end
			hwob_pkg::MODE_SUMMARY: begin
				cnt   = total_q;
				agree = acc_q == total_q;
			end
			default: begin
				stat = hwob_pkg::STAT_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= in_mode;
			index_q <= in_index;
		end
		if (cmd.commit) begin
			out_status   <= stat;
			out_count    <= hwob_pkg::OUT_W'(cnt);
			out_largest  <= largest_nx;
			out_overflow <= hwob_pkg::OUT_W'(ovf_nx);
			out_agree    <= agree;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			acc_en_s1 <= 1'b0;
			acc_q     <= '0;
			total_q   <= '0;
			ovf_q     <= '0;
			largest_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.sum_step;
			if (cmd.sum_start) begin
				ptr_q <= '0;
			end else if (cmd.clr_step || cmd.sum_step) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (cmd.sum_start) begin
				acc_q <= '0;
			end else if (acc_en_s1) begin
				acc_q <= acc_sum[COUNT_WIDTH] ? '1 : acc_sum[COUNT_WIDTH-1:0];
			end
			if (cmd.commit) begin
				total_q   <= total_nx;
				ovf_q     <= ovf_nx;
				largest_q <= largest_nx;
			end
			if (cmd.commit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;

	assign sts.clr_last   = ptr_q == LAST_BIN;
	assign sts.sum_last   = ptr_q == last_idx;
	assign sts.is_summary = mode_q == hwob_pkg::MODE_SUMMARY;
	assign sts.out_free   = !valid_q || out_ready;

endmodule

// ===== hdl/histogram_with_overflow_bin.sv =====
// Histogram with overflow bin: a bank of NUM_BINS saturating counters in a
// single RAM. After reset the block runs a clearing pass that zeroes every
// bin; s_axis_tready stays low meanwhile, while the APB register can be
// written as usual. Each request then takes one of these paths: record
// (mode 0) and read (mode 1, and the unused mode 3) go from accept to a bin
// read, then write-back plus result, before the next accept, because the
// bin RAM has one registered read port and the increment needs the read
// data first. A summary (mode 2) walks the bins in use one per
// cycle through that read port and adds up the bin counts that it
// reads. Results sit in an output register, so a request is accepted while
// the previous result still waits; a result only blocks the block when a
// second one is ready before the first is taken. Counters saturate at all
// ones of COUNT_WIDTH bits; count_value and overflow_total show their low
// 32 bits. bins_in_use of zero acts as one, above NUM_BINS as NUM_BINS, and
// must only change while no request is in flight.
// Depends on hwob_pkg, hwob_ctrl, hwob_dp, hwob_ram.
`timescale 1ns / 1ps

module histogram_with_overflow_bin #(
	parameter int NUM_BINS    = hwob_pkg::DEF_NUM_BINS,
	parameter int COUNT_WIDTH = hwob_pkg::DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,

	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] bin_index
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode

	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] count_value, [47:32] largest_index_seen, [79:48] overflow_total,
	// [80] sums_agree, [87:81] zero
	output logic [87:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] status

	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	hwob_pkg::cmd_t cmd;
	hwob_pkg::sts_t sts;

	logic [hwob_pkg::CFG_W-1:0]    bins_q;
	logic [hwob_pkg::OUT_W-1:0]    res_count, res_overflow;
	logic [hwob_pkg::IN_IDX_W-1:0] res_largest;
	logic                          res_agree;

	// bins_in_use register at byte address 0; address 4 and up hit nothing
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(bins_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= hwob_pkg::CFG_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			bins_q <= pwdata[hwob_pkg::CFG_W-1:0];
		end
	end

	hwob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hwob_dp #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_bins     (bins_q),
		.in_mode      (s_axis_tuser),
		.in_index     (s_axis_tdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (m_axis_tuser),
		.out_count    (res_count),
		.out_largest  (res_largest),
		.out_overflow (res_overflow),
		.out_agree    (res_agree)
	);

	assign m_axis_tdata = {7'd0, res_agree, res_overflow, res_largest, res_count};

endmodule

// ===== hdl/hwob_checker.sv =====
// Port-level checks of the histogram block, bound to its top level.
// Depends on histogram_with_overflow_bin_macros.svh.
`timescale 1ns / 1ps
`include "histogram_with_overflow_bin_macros.svh"

module hwob_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// one request at a time: busy right after an accept
	`HWOB_ASSERT_NXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

	// a result needs at least the bin read before it shows
	`HWOB_ASSERT_NXT(a_no_early_result, clk, arst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")

	// a pending result stays until taken
	`HWOB_ASSERT_NXT(a_result_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

	// bins_in_use reads back what was written
	`HWOB_ASSERT_NXT(a_cfg_readback, clk, arst_n, psel && penable && pwrite && !paddr[2], paddr[2] || prdata[10:0] == $past(pwdata[10:0]), "register readback mismatch")

endmodule

bind histogram_with_overflow_bin hwob_checker u_hwob_checker (.*);
